FILE: sv/hbs_pkg.sv
// hbs_pkg: shared types and constants of the height map bilinear sampler
// no dependencies; imported by the controller, the datapath and the top level

package hbs_pkg;

   localparam int RES_W     = 7;
   localparam int COORD_W   = 18;
   localparam int UCOORD_W  = 17;
   localparam int FRAC_W    = 16;
   localparam int HEIGHT_W  = 16;
   localparam int INDEX_W   = 12;
   localparam int BASE_W    = 14;
   localparam int ACC_H_W   = 32;
   localparam int ACC_V_W   = 48;

   localparam logic [RES_W-1:0]    RES_RESET = 7'd64;
   localparam logic [UCOORD_W-1:0] COORD_ONE = 17'h10000;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_BASE,
      ST_RD00,
      ST_RD10,
      ST_RD01,
      ST_RD11,
      ST_ROW1,
      ST_VSUM,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CORNER_00,
      CORNER_10,
      CORNER_01,
      CORNER_11
   } corner_type;

   typedef struct packed {
      logic       wr_en;
      logic       load_query;
      logic       scale;
      logic       base;
      logic       rd_en;
      corner_type corner;
      logic       h_first;
      logic       h_add;
      logic       v_first;
      logic       v_add;
      logic       out_load;
   } cmd_type;

   function automatic logic [UCOORD_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
      logic [UCOORD_W-1:0] r;
      if (c < 0) begin
         r = '0;
      end else if (c > $signed({1'b0, COORD_ONE})) begin
         r = COORD_ONE;
      end else begin
         r = c[UCOORD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/hbs_ram.sv
// hbs_ram: generic single-port ram with registered read
// no dependencies; holds the height samples

module hbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/hbs_ctrl.sv
// hbs_ctrl: sequencer of the height map bilinear sampler
// depends on hbs_pkg; drives the datapath with a command struct, owns the handshakes

module hbs_ctrl
   import hbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_kind,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_QUERY) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_BASE;
         ST_BASE:  state_in = ST_RD00;
         ST_RD00:  state_in = ST_RD10;
         ST_RD10:  state_in = ST_RD01;
         ST_RD01:  state_in = ST_RD11;
         ST_RD11:  state_in = ST_ROW1;
         ST_ROW1:  state_in = ST_VSUM;
         ST_VSUM:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.wr_en      = req_valid && req_kind == KIND_WRITE;
            cmd.load_query = req_valid && req_kind == KIND_QUERY;
         end
         ST_SCALE: cmd.scale = 1'b1;
         ST_BASE:  cmd.base  = 1'b1;
         ST_RD00: begin
            cmd.rd_en  = 1'b1;
            cmd.corner = CORNER_00;
         end
         ST_RD10: begin
            cmd.rd_en   = 1'b1;
            cmd.corner  = CORNER_10;
            cmd.h_first = 1'b1;
         end
         ST_RD01: begin
            cmd.rd_en  = 1'b1;
            cmd.corner = CORNER_01;
            cmd.h_add  = 1'b1;
         end
         ST_RD11: begin
            cmd.rd_en   = 1'b1;
            cmd.corner  = CORNER_11;
            cmd.h_first = 1'b1;
            cmd.v_first = 1'b1;
         end
         ST_ROW1:  cmd.h_add = 1'b1;
         ST_VSUM:  cmd.v_add = 1'b1;
         ST_DONE:  cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/hbs_datapath.sv
// hbs_datapath: coordinate scaling, sample addressing, blend accumulators
// depends on hbs_pkg; driven by hbs_ctrl, talks to the sample ram

module hbs_datapath
   import hbs_pkg::*;
#(
   parameter int MAX_RES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmd_type                              cmd,
   input  logic                                 csr_we,
   input  logic [RES_W-1:0]                     csr_wdata,
   input  logic [INDEX_W-1:0]                   req_sample_index,
   input  logic [HEIGHT_W-1:0]                  req_sample_value,
   input  logic signed [COORD_W-1:0]            req_coord_u,
   input  logic signed [COORD_W-1:0]            req_coord_v,
   output logic                                 mem_we,
   output logic [$clog2(MAX_RES*MAX_RES)-1:0]   mem_addr,
   output logic [HEIGHT_W-1:0]                  mem_wdata,
   input  logic [HEIGHT_W-1:0]                  mem_rdata,
   output logic [HEIGHT_W-1:0]                  rsp_height
);

   localparam int DEPTH = MAX_RES * MAX_RES;
   localparam int AW    = $clog2(DEPTH);

   logic [RES_W-1:0]    res_ff;
   logic [RES_W-1:0]    res_eff;
   logic [RES_W-1:0]    last;
   logic [UCOORD_W-1:0] u_ff, v_ff;
   logic [RES_W-1:0]    x0_ff, z0_ff, x1_ff;
   logic [FRAC_W-1:0]   tx_ff, tz_ff;
   logic [BASE_W-1:0]   base0_ff, base1_ff;
   logic [ACC_H_W-1:0]  acc_h_ff, acc_h_in;
   logic [ACC_V_W-1:0]  acc_v_ff, acc_v_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;

   logic [23:0]          xs, zs;
   logic [RES_W:0]       x0p1, z0p1;
   logic [RES_W-1:0]     x1, z1;
   logic [BASE_W-1:0]    rd_base;
   logic [RES_W-1:0]     rd_col;
   logic [BASE_W-1:0]    rd_addr14;
   logic [31:0]          rd_ext, wr_ext;
   logic [UCOORD_W-1:0]  wx0, wz0, wx_sel, wz_sel;
   logic [32:0]          h_prod;
   logic [48:0]          v_prod;
   logic [48:0]          rounded;

   // resolution register and its saturation to the grid size
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else if (csr_we) begin
         res_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (32'(res_ff) > MAX_RES) begin
         res_eff = RES_W'(MAX_RES);
      end else begin
         res_eff = res_ff;
      end
   end

   assign last = res_eff - 7'd1;

   // scaling
   assign xs = {7'd0, u_ff} * {17'd0, last};
   assign zs = {7'd0, v_ff} * {17'd0, last};

   // upper neighbors clamped to the last row or column
   assign x0p1 = {1'b0, x0_ff} + 8'd1;
   assign z0p1 = {1'b0, z0_ff} + 8'd1;
   assign x1   = (x0p1 < {1'b0, last}) ? x0p1[RES_W-1:0] : last;
   assign z1   = (z0p1 < {1'b0, last}) ? z0p1[RES_W-1:0] : last;

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         u_ff <= clamp_coord(req_coord_u);
         v_ff <= clamp_coord(req_coord_v);
      end
      if (cmd.scale) begin
         x0_ff <= xs[FRAC_W+RES_W-1:FRAC_W];
         z0_ff <= zs[FRAC_W+RES_W-1:FRAC_W];
         tx_ff <= xs[FRAC_W-1:0];
         tz_ff <= zs[FRAC_W-1:0];
      end
      if (cmd.base) begin
         x1_ff    <= x1;
         base0_ff <= {7'd0, z0_ff} * {7'd0, res_eff};
         base1_ff <= {7'd0, z1} * {7'd0, res_eff};
      end
   end

   // memory addressing
   always_comb begin
      case (cmd.corner)
         CORNER_00: begin
            rd_base = base0_ff;
            rd_col  = x0_ff;
         end
         CORNER_10: begin
            rd_base = base0_ff;
            rd_col  = x1_ff;
         end
         CORNER_01: begin
            rd_base = base1_ff;
            rd_col  = x0_ff;
         end
         CORNER_11: begin
            rd_base = base1_ff;
            rd_col  = x1_ff;
         end
         default: begin
            rd_base = base0_ff;
            rd_col  = x0_ff;
         end
      endcase
   end

   assign rd_addr14 = rd_base + {7'd0, rd_col};
   assign rd_ext    = 32'(rd_addr14);
   assign wr_ext    = 32'(req_sample_index);

   assign mem_we    = cmd.wr_en && (wr_ext < DEPTH);
   assign mem_addr  = cmd.rd_en ? rd_ext[AW-1:0] : wr_ext[AW-1:0];
   assign mem_wdata = req_sample_value;

   // horizontal then vertical blends
   assign wx0    = COORD_ONE - {1'b0, tx_ff};
   assign wz0    = COORD_ONE - {1'b0, tz_ff};
   assign wx_sel = cmd.h_first ? wx0 : {1'b0, tx_ff};
   assign wz_sel = cmd.v_first ? wz0 : {1'b0, tz_ff};

   assign h_prod = {17'd0, mem_rdata} * {16'd0, wx_sel};
   assign v_prod = {17'd0, acc_h_ff} * {32'd0, wz_sel};

   always_comb begin
      acc_h_in = acc_h_ff;
      if (cmd.h_first) begin
         acc_h_in = h_prod[ACC_H_W-1:0];
      end else if (cmd.h_add) begin
         acc_h_in = acc_h_ff + h_prod[ACC_H_W-1:0];
      end
   end

   always_comb begin
      acc_v_in = acc_v_ff;
      if (cmd.v_first) begin
         acc_v_in = v_prod[ACC_V_W-1:0];
      end else if (cmd.v_add) begin
         acc_v_in = acc_v_ff + v_prod[ACC_V_W-1:0];
      end
   end

   // round to nearest unorm16
   assign rounded   = {1'b0, acc_v_ff} + 49'h0_8000_0000;
   assign height_in = (res_eff == '0) ? '0 : rounded[ACC_V_W-1:ACC_V_W-HEIGHT_W];

   always_ff @(posedge clock) begin
      acc_h_ff <= acc_h_in;
      acc_v_ff <= acc_v_in;
      if (cmd.out_load) begin
         height_ff <= height_in;
      end
   end

   assign rsp_height = height_ff;

endmodule

FILE: sv/heightmap_bilinear_sampler.sv
// Height map bilinear sampler. Holds a square grid of unorm16 heights of up to
// MAX_RES x MAX_RES samples in one single-port ram; write items fill it at
// row * resolution + column, and query items return the bilinear blend at the
// clamped Q1.16 coordinates, rounded to nearest. After a write item the next
// item is accepted in the following cycle. A query item, from acceptance until
// its result sits in the output register, scales both coordinates, forms the
// two row base addresses, issues the four sample reads through the single ram
// port, and then finishes the blends and rounds. The next item is accepted once
// the block is back in idle, so a query holds the input until its result is
// loaded. A result waiting on rsp_ready holds the block only once its next
// query result is ready. Sample entries read before they were written return
// arbitrary heights. Resolution is to be written through csr_we / csr_wdata
// only while the block is idle, which the block itself does not enforce; values
// above MAX_RES act as MAX_RES, and zero makes every query return zero.
// depends on hbs_pkg, hbs_ctrl, hbs_datapath and hbs_ram

module heightmap_bilinear_sampler
   import hbs_pkg::*;
#(
   parameter int MAX_RES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_kind,
   input  logic [INDEX_W-1:0]         req_sample_index,
   input  logic [HEIGHT_W-1:0]        req_sample_value,
   input  logic signed [COORD_W-1:0]  req_coord_u,
   input  logic signed [COORD_W-1:0]  req_coord_v,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [HEIGHT_W-1:0]        rsp_height,
   input  logic                       csr_we,
   input  logic [RES_W-1:0]           csr_wdata
);

   localparam int DEPTH = MAX_RES * MAX_RES;
   localparam int AW    = $clog2(DEPTH);

   cmd_type             cmd;
   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic [HEIGHT_W-1:0] mem_wdata;
   logic [HEIGHT_W-1:0] mem_rdata;

   hbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   hbs_datapath #(
      .MAX_RES (MAX_RES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_sample_index (req_sample_index),
      .req_sample_value (req_sample_value),
      .req_coord_u      (req_coord_u),
      .req_coord_v      (req_coord_v),
      .mem_we           (mem_we),
      .mem_addr         (mem_addr),
      .mem_wdata        (mem_wdata),
      .mem_rdata        (mem_rdata),
      .rsp_height       (rsp_height)
   );

   hbs_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

FILE: bench/height_scoreboard.sv
`timescale 1ns / 100ps
// height_check_pkg: scoreboard for the bilinear height sampler; keeps its own copy of the
// grid and the resolution, predicts each query height and checks results in order
// depends on hbs_pkg for field widths and item kinds

package height_check_pkg;
   import hbs_pkg::*;

   localparam int GRID_EDGE  = 64;
   localparam int GRID_CELLS = GRID_EDGE * GRID_EDGE;
   localparam int ONE_Q16    = 65536;

   class height_scoreboard;
      logic [HEIGHT_W-1:0] grid [GRID_CELLS];
      logic [RES_W-1:0]    resolution;
      logic [HEIGHT_W-1:0] pending_heights [$];
      int unsigned         items_seen;
      int unsigned         queries_seen;
      int unsigned         heights_checked;
      int unsigned         mismatches;

      function new();
         resolution      = RES_RESET;
         items_seen      = 0;
         queries_seen    = 0;
         heights_checked = 0;
         mismatches      = 0;
      endfunction

      function void set_resolution(input logic [RES_W-1:0] value);
         resolution = value;
      endfunction

      function int unsigned effective_res();
         return (resolution > GRID_EDGE) ? GRID_EDGE : int'(resolution);
      endfunction

      function logic [UCOORD_W-1:0] saturate_coord(input logic signed [COORD_W-1:0] c);
         if (c < 0) begin
            return '0;
         end
         if (c > ONE_Q16) begin
            return UCOORD_W'(ONE_Q16);
         end
         return c[UCOORD_W-1:0];
      endfunction

      // four corner addresses (00, 10, 01, 11) and fractions; returns how many are read
      function int unsigned locate(input logic signed [COORD_W-1:0] u,
                                   input logic signed [COORD_W-1:0] v,
                                   output int unsigned corner_addr [4],
                                   output int unsigned tx,
                                   output int unsigned tz);
         int unsigned res, last, xs, zs, x0, z0, x1, z1;
         res = effective_res();
         corner_addr = '{default: 0};
         tx = 0;
         tz = 0;
         if (res == 0) begin
            return 0;
         end
         last = res - 1;
         xs = saturate_coord(u) * last;
         zs = saturate_coord(v) * last;
         x0 = xs >> 16;
         z0 = zs >> 16;
         tx = xs & 32'hFFFF;
         tz = zs & 32'hFFFF;
         x1 = (x0 + 1 < last) ? x0 + 1 : last;
         z1 = (z0 + 1 < last) ? z0 + 1 : last;
         corner_addr[0] = z0 * res + x0;
         corner_addr[1] = z0 * res + x1;
         corner_addr[2] = z1 * res + x0;
         corner_addr[3] = z1 * res + x1;
         return 4;
      endfunction

      function logic [HEIGHT_W-1:0] predict_height(input logic signed [COORD_W-1:0] u,
                                                   input logic signed [COORD_W-1:0] v);
         int unsigned corner_addr [4];
         int unsigned tx, tz;
         logic [63:0] hx0, hx1, sum;
         if (locate(u, v, corner_addr, tx, tz) == 0) begin
            return '0;
         end
         hx0 = 64'(grid[corner_addr[0]]) * 64'(ONE_Q16 - tx)
             + 64'(grid[corner_addr[1]]) * 64'(tx);
         hx1 = 64'(grid[corner_addr[2]]) * 64'(ONE_Q16 - tx)
             + 64'(grid[corner_addr[3]]) * 64'(tx);
         sum = hx0 * 64'(ONE_Q16 - tz) + hx1 * 64'(tz);
         return HEIGHT_W'((sum + 64'h8000_0000) >> 32);
      endfunction

      function void note_item(input logic kind,
                              input logic [INDEX_W-1:0] index,
                              input logic [HEIGHT_W-1:0] value,
                              input logic signed [COORD_W-1:0] u,
                              input logic signed [COORD_W-1:0] v);
         items_seen++;
         if (kind == KIND_WRITE) begin
            grid[index] = value;
         end else begin
            queries_seen++;
            pending_heights = {pending_heights, predict_height(u, v)};
         end
      endfunction

      function void check_height(input logic [HEIGHT_W-1:0] actual);
         logic [HEIGHT_W-1:0] want;
         if (pending_heights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected height %0d with no query pending", actual);
            end
            return;
         end
         want = pending_heights.pop_front();
         heights_checked++;
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("height mismatch: expected %0d, got %0d", want, actual);
            end
         end
      endfunction
   endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives write and query items into heightmap_bilinear_sampler across several
// resolutions and idle patterns, and checks every height against height_scoreboard
// depends on hbs_pkg, height_check_pkg and the sampler rtl

module tb_top;
   import hbs_pkg::*;
   import height_check_pkg::*;

   localparam int QUIET_LIMIT   = 5000;
   localparam int LONG_HOLD     = 500;
   localparam int SETTLE_CYCLES = 16;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_kind;
   logic [INDEX_W-1:0]        req_sample_index;
   logic [HEIGHT_W-1:0]       req_sample_value;
   logic signed [COORD_W-1:0] req_coord_u;
   logic signed [COORD_W-1:0] req_coord_v;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [HEIGHT_W-1:0]       rsp_height;
   logic                      csr_we;
   logic [RES_W-1:0]          csr_wdata;

   height_scoreboard heights;
   bit               written_addr [GRID_CELLS];
   int unsigned      sender_idle_pct = 0;
   int unsigned      stall_pct = 0;
   logic             hold_req = 1'b0;
   bit               hold_done = 1'b0;
   int unsigned      quiet_cycles = 0;
   int unsigned      items_sent = 0;

   heightmap_bilinear_sampler #(
      .MAX_RES (GRID_EDGE)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sample_index (req_sample_index),
      .req_sample_value (req_sample_value),
      .req_coord_u      (req_coord_u),
      .req_coord_v      (req_coord_v),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_height       (rsp_height),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // observe both channels and the register port at each edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (csr_we) begin
            heights.set_resolution(csr_wdata);
         end
         if (req_valid && req_ready) begin
            heights.note_item(req_kind, req_sample_index, req_sample_value,
                              req_coord_u, req_coord_v);
         end
         if (rsp_valid && rsp_ready) begin
            heights.check_height(rsp_height);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic logic signed [COORD_W-1:0] rand_coord();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return COORD_W'($urandom_range(0, ONE_Q16));
      end
      if (pick < 80) begin
         return $urandom_range(0, 1) ? COORD_W'(ONE_Q16) : '0;
      end
      return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
   endfunction

   task automatic set_flow(input flow_mode_type mode);
      case (mode)
         FLOW_FREE: begin
            sender_idle_pct = 0;
            stall_pct <= 0;
         end
         FLOW_SENDER_IDLE: begin
            sender_idle_pct = 70;
            stall_pct <= 0;
         end
         FLOW_RECEIVER_STALL: begin
            sender_idle_pct = 0;
            stall_pct <= 70;
         end
         default: begin
            sender_idle_pct = 38;
            stall_pct <= 38;
         end
      endcase
   endtask

   task automatic send_item(input logic kind,
                            input logic [INDEX_W-1:0] index,
                            input logic [HEIGHT_W-1:0] value,
                            input logic signed [COORD_W-1:0] u,
                            input logic signed [COORD_W-1:0] v);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_sample_index <= index;
      req_sample_value <= value;
      req_coord_u      <= u;
      req_coord_v      <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_write(input int unsigned index, input int unsigned value);
      send_item(KIND_WRITE, INDEX_W'(index), HEIGHT_W'(value), rand_coord(), rand_coord());
      written_addr[index] = 1'b1;
   endtask

   // fill any corner the query would read that has never been written
   task automatic issue_query(input logic signed [COORD_W-1:0] u,
                              input logic signed [COORD_W-1:0] v);
      int unsigned corner_addr [4];
      int unsigned tx, tz, count;
      count = heights.locate(u, v, corner_addr, tx, tz);
      for (int i = 0; i < count; i++) begin
         if (!written_addr[corner_addr[i]]) begin
            send_write(corner_addr[i], $urandom_range(0, 65535));
         end
      end
      send_item(KIND_QUERY, INDEX_W'($urandom_range(0, GRID_CELLS - 1)),
                HEIGHT_W'($urandom_range(0, 65535)), u, v);
   endtask

   task automatic random_item();
      int unsigned span;
      span = heights.effective_res() * heights.effective_res();
      if (span == 0) begin
         span = GRID_CELLS;
      end
      if ($urandom_range(0, 99) < 30) begin
         if ($urandom_range(0, 1)) begin
            send_write($urandom_range(0, GRID_CELLS - 1), $urandom_range(0, 65535));
         end else begin
            send_write($urandom_range(0, span - 1), $urandom_range(0, 65535));
         end
      end else begin
         issue_query(rand_coord(), rand_coord());
      end
   endtask

   // random items until about count items went in, corner fills included
   task automatic run_items(input int unsigned count);
      int unsigned stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) random_item();
   endtask

   // let the block drain before touching the register
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (heights.pending_heights.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_resolution(input int unsigned value);
      csr_we    <= 1'b1;
      csr_wdata <= RES_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned res, input flow_mode_type mode,
                            input int unsigned count, input bit long_hold);
      write_resolution(res);
      set_flow(mode);
      if (long_hold) begin
         hold_req <= 1'b1;
      end
      run_items(count);
      settle();
   endtask

   task automatic directed_items();
      send_write(0, 16'hFFFF);
      send_write(1, 16'hFFFF);
      send_write(GRID_EDGE, 16'hFFFF);
      send_write(GRID_EDGE + 1, 16'hFFFF);
      issue_query(18'sd1000, 18'sd1000);
      issue_query(18'h20000, -18'sd1);
      send_write(GRID_CELLS - 1, 0);
      issue_query(18'sd65536, 18'sd65536);
      issue_query(18'h1FFFF, 18'h1FFFF);
      issue_query(18'h20000, 18'h1FFFF);
      issue_query(18'sd65537, 18'sd0);
      issue_query(18'sd32768, 18'sd49152);
      issue_query(18'sd65535, 18'sd1);
   endtask

   initial begin
      heights = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_WRITE;
      req_sample_index <= '0;
      req_sample_value <= '0;
      req_coord_u      <= '0;
      req_coord_v      <= '0;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_flow(FLOW_FREE);
      directed_items();
      run_items(100);
      settle();

      run_phase(0, FLOW_SENDER_IDLE, 80, 1'b0);
      run_phase(1, FLOW_RECEIVER_STALL, 80, 1'b0);
      run_phase(2, FLOW_BOTH, 100, 1'b0);
      run_phase(127, FLOW_FREE, 150, 1'b1);
      run_phase($urandom_range(3, 63), FLOW_SENDER_IDLE, 130, 1'b0);
      run_phase(65, FLOW_RECEIVER_STALL, 100, 1'b0);
      run_phase(64, FLOW_BOTH, 130, 1'b0);
      run_phase($urandom_range(2, 64), FLOW_FREE, 130, 1'b0);
      repeat (20) @(posedge clock);

      $display("sent %0d items (%0d queries), checked %0d heights, %0d mismatches",
               heights.items_seen, heights.queries_seen, heights.heights_checked,
               heights.mismatches);
      $display("resolutions 64, 0, 1, 2, 65, 127 and random; idle, stall and hold-off phases");
      if (heights.mismatches == 0 && heights.pending_heights.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d heights never returned", heights.pending_heights.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/hbs_pkg.sv
sv/hbs_ram.sv
sv/hbs_ctrl.sv
sv/hbs_datapath.sv
sv/heightmap_bilinear_sampler.sv
bench/height_scoreboard.sv
bench/tb_top.sv
